/* design/ats_pkg.sv */
// ----------------------------------------------------------------------------
// Autoscroll tick generator package
// Shared widths, limits, sequencer and divider types, and the stepped
// interval table used by the tick generator and its divider.
// ----------------------------------------------------------------------------
package ats_pkg;

    // Shared divider geometry: the widest dividend is the jog product
    // (slow - fast) * past, which stays below 2^23.
    localparam int DIV_W  = 23;
    localparam int DIVR_W = 11;
    localparam int IVL_W  = 12;

    // Wheel detent sizes in thousandths.
    localparam int HIRES_MULTIPLIER = 120;
    localparam logic [17:0] DETENT_LO = 18'd1000;
    localparam logic [17:0] DETENT_HI = 18'(1000 * HIRES_MULTIPLIER);

    // Register limits applied where the registers are used.
    localparam logic [8:0]  SPEED_MIN = 9'd25;
    localparam logic [8:0]  SPEED_MAX = 9'd400;
    localparam logic [7:0]  DZ_MAX    = 8'd200;
    localparam logic [10:0] SPAN_MIN  = 11'd50;
    localparam logic [10:0] SPAN_MAX  = 11'd2000;
    localparam logic [IVL_W-1:0] MIN_INTERVAL = IVL_W'(5);
    localparam logic signed [4:0] LEVEL_MAX = 5'sd9;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SPEED_PERCENT    = 3'd0;
    localparam logic [2:0] CFG_JOG_DEADZONE     = 3'd1;
    localparam logic [2:0] CFG_JOG_SPAN         = 3'd2;
    localparam logic [2:0] CFG_INVERT_DIRECTION = 3'd3;
    localparam logic [2:0] CFG_HIRES_WHEEL      = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PLAN,
        ST_LAUNCH,
        ST_DIV_WAIT,
        ST_MUL,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_STEP,
        OP_SLOW,
        OP_FAST,
        OP_JOG
    } div_op_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // Stepped interval table scaled by 100, so that dividing by the speed in
    // percent gives the interval in milliseconds.
    function automatic logic [16:0] step_x100(input logic [3:0] idx);
        logic [16:0] v;
        begin
            case (idx)
                4'd0:    v = 17'd100000;
                4'd1:    v = 17'd50000;
                4'd2:    v = 17'd20000;
                4'd3:    v = 17'd10000;
                4'd4:    v = 17'd6700;
                4'd5:    v = 17'd5000;
                4'd6:    v = 17'd4000;
                4'd7:    v = 17'd3300;
                4'd8:    v = 17'd2500;
                default: v = 17'd100000;
            endcase
            return v;
        end
    endfunction

endpackage

/* design/ats_div.sv */
// ----------------------------------------------------------------------------
// Autoscroll shared divider
// Restoring unsigned divider, one quotient bit per cycle, shared by all the
// interval calculations of the tick generator.
// ----------------------------------------------------------------------------
module ats_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  ats_pkg::div_req_t req,
    output ats_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(ats_pkg::DIV_W + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [ats_pkg::DIVR_W-1:0]    rem_reg;
    logic [ats_pkg::DIVR_W-1:0]    dvs_reg;
    logic [ats_pkg::DIV_W-1:0]     quo_reg;

    logic [ats_pkg::DIVR_W:0]      trial;
    logic                          fits;

    // The dividend shifts out of the top of quo_reg as quotient bits enter below.
    assign trial = {rem_reg, quo_reg[ats_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ats_pkg::DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            dvs_reg <= req.divisor;
            quo_reg <= req.dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? ats_pkg::DIVR_W'(trial - {1'b0, dvs_reg})
                            : trial[ats_pkg::DIVR_W-1:0];
            quo_reg <= {quo_reg[ats_pkg::DIV_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* design/autoscroll_tick_generator.sv */
// Processing: a word with no scrolling active passes through update, plan and finish; stepped
// mode adds one division by the speed (23 quotient bits), jog mode past the span two divisions
// and jog mode inside it three divisions and one multiply, all on the shared divider.
// One word is worked on at a time: a new word is accepted only once the last result is
// loaded, which waits while an earlier result is held. Reset (aresetn low, synchronous)
// clears level, jog mode, deflection, tick time and edge history and restores defaults.
// ----------------------------------------------------------------------------
// Autoscroll tick generator
// Turns control bits and vertical ball motion into periodic wheel detents,
// using a small sequencer around one shared iterative divider.
// ----------------------------------------------------------------------------
module autoscroll_tick_generator (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: time_ms[31:0], ball_dy[47:32], jog_hold[48], step_up[49],
    //          step_down[50], stop_request[51], zero padding[55:52]
    input  logic [55:0] s_tdata,
    // s_tuser: motion_to_jog[0]
    input  logic        s_tuser,
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: wheel_amount[17:0], scroll_level[22:18], jog_mode[23]
    output logic [23:0] m_tdata,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_wdata
);

    localparam int IW = ats_pkg::IVL_W;
    localparam int DW = ats_pkg::DIV_W;

    // Configuration registers.
    logic [8:0]  speed_reg;
    logic [7:0]  dz_reg;
    logic [10:0] span_reg;
    logic        invert_reg;
    logic        hires_reg;

    // Sequencer and item state.
    ats_pkg::state_t  state_reg, state_next;
    ats_pkg::div_op_t op_reg, op_next;

    logic [31:0]        time_reg, time_next;
    logic signed [15:0] dy_reg, dy_next;
    logic               to_jog_reg, to_jog_next;
    logic [3:0]         ctl_reg, ctl_next;       // up, down, stop, hold
    logic [2:0]         prev_bits_reg, prev_bits_next;
    logic signed [4:0]  level_reg, level_next;
    logic               jog_reg, jog_next;
    logic signed [12:0] defl_reg, defl_next;
    logic [31:0]        last_tick_reg, last_tick_next;
    logic               dir_act_reg, dir_act_next;
    logic               dir_neg_reg, dir_neg_next;
    logic [3:0]         idx_reg, idx_next;
    logic [IW-1:0]      past_reg, past_next;
    logic [IW-1:0]      slow_reg, slow_next;
    logic [IW-1:0]      fast_reg, fast_next;
    logic [IW-1:0]      ivl_reg, ivl_next;
    logic [DW-1:0]      prod_reg, prod_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [23:0]        m_tdata_reg, m_tdata_next;

    // Saturated register values.
    logic [8:0]  spd_sat;
    logic [7:0]  dz_sat;
    logic [10:0] span_sat;

    ats_pkg::div_req_t div_req;
    ats_pkg::div_rsp_t div_rsp;
    logic [IW-1:0]     q_min;

    assign spd_sat  = (speed_reg < ats_pkg::SPEED_MIN) ? ats_pkg::SPEED_MIN :
                      (speed_reg > ats_pkg::SPEED_MAX) ? ats_pkg::SPEED_MAX : speed_reg;
    assign dz_sat   = (dz_reg > ats_pkg::DZ_MAX) ? ats_pkg::DZ_MAX : dz_reg;
    assign span_sat = (span_reg < ats_pkg::SPAN_MIN) ? ats_pkg::SPAN_MIN :
                      (span_reg > ats_pkg::SPAN_MAX) ? ats_pkg::SPAN_MAX : span_reg;

    // Stepped intervals never fall below the minimum interval.
    assign q_min = (div_rsp.quotient < DW'(ats_pkg::MIN_INTERVAL)) ? ats_pkg::MIN_INTERVAL
                                                                   : div_rsp.quotient[IW-1:0];

    // The divider is started from the launch state only; its operands come
    // from registers through the interval table and the register limits.
    always_comb begin
        div_req.start = (state_reg == ats_pkg::ST_LAUNCH);
        case (op_reg)
            ats_pkg::OP_STEP: begin
                div_req.dividend = DW'(ats_pkg::step_x100(idx_reg));
                div_req.divisor  = 11'(spd_sat);
            end
            ats_pkg::OP_SLOW: begin
                div_req.dividend = DW'(ats_pkg::step_x100(4'd0));
                div_req.divisor  = 11'(spd_sat);
            end
            ats_pkg::OP_FAST: begin
                div_req.dividend = DW'(ats_pkg::step_x100(4'd8));
                div_req.divisor  = 11'(spd_sat);
            end
            ats_pkg::OP_JOG: begin
                div_req.dividend = prod_reg;
                div_req.divisor  = span_sat;
            end
            default: begin
                div_req.dividend = prod_reg;
                div_req.divisor  = span_sat;
            end
        endcase
    end

    ats_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Configuration writes land directly; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg  <= 9'd100;
            dz_reg     <= 8'd15;
            span_reg   <= 11'd300;
            invert_reg <= 1'b0;
            hires_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                ats_pkg::CFG_SPEED_PERCENT:    speed_reg  <= cfg_wdata[8:0];
                ats_pkg::CFG_JOG_DEADZONE:     dz_reg     <= cfg_wdata[7:0];
                ats_pkg::CFG_JOG_SPAN:         span_reg   <= cfg_wdata;
                ats_pkg::CFG_INVERT_DIRECTION: invert_reg <= cfg_wdata[0];
                ats_pkg::CFG_HIRES_WHEEL:      hires_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Next state and datapath.
    always_comb begin
        logic [2:0]         rise;
        logic signed [4:0]  u_lvl;
        logic               u_jog;
        logic signed [12:0] u_defl;
        logic signed [16:0] u_sum;
        logic signed [16:0] u_lim;
        logic [12:0]        d_abs;
        logic [IW-1:0]      mag;
        logic [3:0]         lvl_abs;
        logic [31:0]        elapsed;
        logic               fire;
        logic [17:0]        detent;
        logic [17:0]        amount;
        logic [2*IW-1:0]    prod_full;

        state_next     = state_reg;
        op_next        = op_reg;
        time_next      = time_reg;
        dy_next        = dy_reg;
        to_jog_next    = to_jog_reg;
        ctl_next       = ctl_reg;
        prev_bits_next = prev_bits_reg;
        level_next     = level_reg;
        jog_next       = jog_reg;
        defl_next      = defl_reg;
        last_tick_next = last_tick_reg;
        dir_act_next   = dir_act_reg;
        dir_neg_next   = dir_neg_reg;
        idx_next       = idx_reg;
        past_next      = past_reg;
        slow_next      = slow_reg;
        fast_next      = fast_reg;
        ivl_next       = ivl_reg;
        prod_next      = prod_reg;
        m_tdata_next   = m_tdata_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;

        rise  = ctl_reg[2:0] & ~prev_bits_reg;
        u_lvl = level_reg;
        u_jog = jog_reg;
        u_defl = defl_reg;
        u_sum = '0;
        u_lim = $signed({5'b0, 12'({1'b0, dz_sat} + {1'b0, span_sat})});
        d_abs = defl_reg[12] ? 13'(-defl_reg) : 13'(defl_reg);
        mag   = d_abs[IW-1:0];
        lvl_abs = level_reg[4] ? 4'(-level_reg) : 4'(level_reg);
        elapsed = time_reg - last_tick_reg;
        fire    = dir_act_reg && (elapsed >= 32'(ivl_reg));
        detent  = hires_reg ? ats_pkg::DETENT_HI : ats_pkg::DETENT_LO;
        amount  = (dir_neg_reg ^ invert_reg) ? 18'(18'd0 - detent) : detent;
        prod_full = (slow_reg - fast_reg) * past_reg;

        case (state_reg)
            ats_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    time_next   = s_tdata[31:0];
                    dy_next     = $signed(s_tdata[47:32]);
                    to_jog_next = s_tuser;
                    ctl_next    = {s_tdata[48], s_tdata[51:49]};
                    state_next  = ats_pkg::ST_UPDATE;
                end
            end
            ats_pkg::ST_UPDATE: begin
                // Jog entry and exit follow the held jog bit.
                if (ctl_reg[3] && !u_jog) begin
                    u_lvl  = '0;
                    u_defl = '0;
                    u_jog  = 1'b1;
                    last_tick_next = time_reg;
                end else if (!ctl_reg[3] && u_jog) begin
                    u_lvl  = '0;
                    u_defl = '0;
                    u_jog  = 1'b0;
                end
                // A step edge leaves jog mode before moving the level.
                if (rise[0]) begin
                    if (u_jog) begin
                        u_lvl  = '0;
                        u_defl = '0;
                        u_jog  = 1'b0;
                    end
                    u_lvl = (u_lvl + 5'sd1 > ats_pkg::LEVEL_MAX) ? ats_pkg::LEVEL_MAX
                                                                : u_lvl + 5'sd1;
                    last_tick_next = time_reg;
                end
                if (rise[1]) begin
                    if (u_jog) begin
                        u_lvl  = '0;
                        u_defl = '0;
                        u_jog  = 1'b0;
                    end
                    u_lvl = (u_lvl - 5'sd1 < -ats_pkg::LEVEL_MAX) ? -ats_pkg::LEVEL_MAX
                                                                 : u_lvl - 5'sd1;
                    last_tick_next = time_reg;
                end
                if (rise[2]) begin
                    u_lvl  = '0;
                    u_defl = '0;
                    u_jog  = 1'b0;
                end
                // Deflection accumulates and is clamped to deadzone plus span.
                if (u_jog) begin
                    u_sum = 17'(u_defl) + (to_jog_reg ? 17'(dy_reg) : 17'sd0);
                    if (u_sum > u_lim) begin
                        u_sum = u_lim;
                    end else if (u_sum < -u_lim) begin
                        u_sum = -u_lim;
                    end
                    u_defl = 13'(u_sum);
                end
                level_next     = u_lvl;
                jog_next       = u_jog;
                defl_next      = u_defl;
                prev_bits_next = ctl_reg[2:0];
                state_next     = ats_pkg::ST_PLAN;
            end
            ats_pkg::ST_PLAN: begin
                dir_act_next = 1'b0;
                if (jog_reg) begin
                    if (mag > IW'(dz_sat)) begin
                        // Ball moved down (positive deflection) scrolls down.
                        dir_act_next = 1'b1;
                        dir_neg_next = !defl_reg[12];
                        past_next    = mag - IW'(dz_sat);
                        op_next      = ats_pkg::OP_SLOW;
                        state_next   = ats_pkg::ST_LAUNCH;
                    end else begin
                        state_next = ats_pkg::ST_FINISH;
                    end
                end else if (level_reg != 5'sd0) begin
                    dir_act_next = 1'b1;
                    dir_neg_next = level_reg[4];
                    idx_next     = lvl_abs - 4'd1;
                    op_next      = ats_pkg::OP_STEP;
                    state_next   = ats_pkg::ST_LAUNCH;
                end else begin
                    state_next = ats_pkg::ST_FINISH;
                end
            end
            ats_pkg::ST_LAUNCH: begin
                state_next = ats_pkg::ST_DIV_WAIT;
            end
            ats_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    case (op_reg)
                        ats_pkg::OP_STEP: begin
                            ivl_next   = q_min;
                            state_next = ats_pkg::ST_FINISH;
                        end
                        ats_pkg::OP_SLOW: begin
                            slow_next  = q_min;
                            op_next    = ats_pkg::OP_FAST;
                            state_next = ats_pkg::ST_LAUNCH;
                        end
                        ats_pkg::OP_FAST: begin
                            fast_next = q_min;
                            // Past the whole span the fastest interval applies.
                            if (past_reg >= IW'(span_sat)) begin
                                ivl_next   = q_min;
                                state_next = ats_pkg::ST_FINISH;
                            end else begin
                                state_next = ats_pkg::ST_MUL;
                            end
                        end
                        ats_pkg::OP_JOG: begin
                            ivl_next   = slow_reg - div_rsp.quotient[IW-1:0];
                            state_next = ats_pkg::ST_FINISH;
                        end
                        default: begin
                            state_next = ats_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            ats_pkg::ST_MUL: begin
                prod_next  = prod_full[DW-1:0];
                op_next    = ats_pkg::OP_JOG;
                state_next = ats_pkg::ST_LAUNCH;
            end
            ats_pkg::ST_FINISH: begin
                // Wait for the output register to free up before loading it.
                if (!m_tvalid_reg || m_tready) begin
                    if (fire) begin
                        last_tick_next = time_reg;
                    end
                    m_tdata_next  = {jog_reg, level_reg, fire ? amount : 18'd0};
                    m_tvalid_next = 1'b1;
                    state_next    = ats_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ats_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ats_pkg::ST_IDLE;
            op_reg        <= ats_pkg::OP_STEP;
            prev_bits_reg <= '0;
            level_reg     <= '0;
            jog_reg       <= 1'b0;
            defl_reg      <= '0;
            last_tick_reg <= '0;
            dir_act_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            prev_bits_reg <= prev_bits_next;
            level_reg     <= level_next;
            jog_reg       <= jog_next;
            defl_reg      <= defl_next;
            last_tick_reg <= last_tick_next;
            dir_act_reg   <= dir_act_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        time_reg    <= time_next;
        dy_reg      <= dy_next;
        to_jog_reg  <= to_jog_next;
        ctl_reg     <= ctl_next;
        dir_neg_reg <= dir_neg_next;
        idx_reg     <= idx_next;
        past_reg    <= past_next;
        slow_reg    <= slow_next;
        fast_reg    <= fast_next;
        ivl_reg     <= ivl_next;
        prod_reg    <= prod_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ats_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* design/ats_checker.sv */
// ----------------------------------------------------------------------------
// Autoscroll tick generator checker
// Port-level assertions on the tick generator, bound to the top level.
// ----------------------------------------------------------------------------
module ats_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    localparam logic [17:0] NEG_LO = 18'(18'd0 - ats_pkg::DETENT_LO);
    localparam logic [17:0] NEG_HI = 18'(18'd0 - ats_pkg::DETENT_HI);

    // One word is worked on at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again straight after an accepted word");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed or dropped");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (($signed(m_tdata[22:18]) <= 5'sd9) &&
                      ($signed(m_tdata[22:18]) >= -5'sd9)))
        else $error("scroll level outside -9..9");

    a_jog_level_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[23]) |-> (m_tdata[22:18] == 5'd0))
        else $error("stepped level non-zero while in jog mode");

    a_amount_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[17:0] == 18'd0) ||
                      (m_tdata[17:0] == ats_pkg::DETENT_LO) ||
                      (m_tdata[17:0] == ats_pkg::DETENT_HI) ||
                      (m_tdata[17:0] == NEG_LO) ||
                      (m_tdata[17:0] == NEG_HI)))
        else $error("wheel amount is not a whole detent");

endmodule

bind autoscroll_tick_generator ats_checker u_ats_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
